### rtl/core/ascon_pkg.sv
// Package: types, constants and the round function of the Ascon AEAD core.
`timescale 1ns / 1ps
`default_nettype none
package ascon_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned NumWords = 5;
  localparam int unsigned RndW    = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned ROUNDS_INIT = 12;
  localparam int unsigned ROUNDS_DATA = 6;

  localparam logic [WordW-1:0] ASCON_IV = 64'h80400c0600000000;
  localparam logic [WordW-1:0] DOMAIN_SEP = 64'h0000000000000001;

  // Round index runs from 12 - rounds up to 11.
  localparam logic [RndW-1:0] RND_START_INIT = RndW'(12 - ROUNDS_INIT);
  localparam logic [RndW-1:0] RND_START_DATA = RndW'(12 - ROUNDS_DATA);
  localparam logic [RndW-1:0] RND_LAST       = RndW'(11);

  localparam logic [CfgIdxW-1:0] CFG_KEY_FIRST  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_KEY_SECOND = CfgIdxW'(1);

  typedef logic [NumWords-1:0][WordW-1:0] state_t;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_AD    = 3'd1,
    MODE_ENC   = 3'd2,
    MODE_DEC   = 3'd3,
    MODE_FIN   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_TAG  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_POST
  } ctrl_state_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD_IV,
    DP_ABSORB,
    DP_KEY_HEAD,
    DP_ROUND,
    DP_KEY_TAIL,
    DP_TEXT
  } dp_op_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [WordW-1:0]  data;
    logic [WordW-1:0]  nonce_second;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  word_out;
    logic [WordW-1:0]  tag_second;
    logic [1:0]        kind;
  } out_item_t;

  typedef struct packed {
    logic            capture;
    dp_op_e          op;
    logic            close_ad;
    logic            decrypt;
    logic [RndW-1:0] rnd;
    logic            out_load;
    kind_e           kind;
  } dp_cmd_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic state_t ascon_round(input state_t s_in, input logic [RndW-1:0] r);
    state_t s;
    state_t t;
    s = s_in;
    s[2] = s[2] ^ {56'd0, ~r, r};
    s[0] = s[0] ^ s[4];
    s[4] = s[4] ^ s[3];
    s[2] = s[2] ^ s[1];
    t[0] = ~s[0] & s[1];
    t[1] = ~s[1] & s[2];
    t[2] = ~s[2] & s[3];
    t[3] = ~s[3] & s[4];
    t[4] = ~s[4] & s[0];
    s[0] = s[0] ^ t[1];
    s[1] = s[1] ^ t[2];
    s[2] = s[2] ^ t[3];
    s[3] = s[3] ^ t[4];
    s[4] = s[4] ^ t[0];
    s[1] = s[1] ^ s[0];
    s[0] = s[0] ^ s[4];
    s[3] = s[3] ^ s[2];
    s[2] = ~s[2];
    s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
    s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
    s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
    s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
    s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
    ascon_round = s;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ascon_ctrl.sv
// Controller: sequences prepare, round and finish steps and holds the phase flags.
`timescale 1ns / 1ps
`default_nettype none
module ascon_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        in_mode_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ascon_pkg::dp_cmd_t     cmd_o
);
  import ascon_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [2:0]      mode_q;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            ad_closed_q, ad_closed_d;
  logic            text_started_q, text_started_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;
  logic            need_rounds;
  logic [RndW-1:0] rnd_start;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    need_rounds = 1'b0;
    rnd_start   = RND_START_DATA;
    case (mode_q)
      MODE_START: begin
        need_rounds = 1'b1;
        rnd_start   = RND_START_INIT;
      end
      MODE_AD:  need_rounds = !ad_closed_q;
      MODE_ENC: need_rounds = text_started_q;
      MODE_DEC: need_rounds = text_started_q;
      MODE_FIN: begin
        need_rounds = 1'b1;
        rnd_start   = RND_START_INIT;
      end
      default: need_rounds = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_PREP;
      ST_PREP:  state_d = need_rounds ? ST_ROUND : ST_POST;
      ST_ROUND: if (rnd_q == RND_LAST) state_d = ST_POST;
      ST_POST:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and register updates
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.kind     = KIND_ACK;
    cmd_o.rnd      = rnd_q;
    rnd_d          = rnd_q;
    ad_closed_d    = ad_closed_q;
    text_started_d = text_started_q;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: cmd_o.capture = accept;
      ST_PREP: begin
        rnd_d = rnd_start;
        case (mode_q)
          MODE_START: cmd_o.op = DP_LOAD_IV;
          MODE_AD:    if (!ad_closed_q) cmd_o.op = DP_ABSORB;
          MODE_ENC, MODE_DEC: begin
            cmd_o.close_ad = !ad_closed_q;
            ad_closed_d    = 1'b1;
          end
          MODE_FIN: begin
            cmd_o.op       = DP_KEY_HEAD;
            cmd_o.close_ad = !ad_closed_q;
            ad_closed_d    = 1'b1;
          end
          default: cmd_o.op = DP_NOP;
        endcase
      end
      ST_ROUND: begin
        cmd_o.op = DP_ROUND;
        rnd_d    = rnd_q + RndW'(1);
      end
      ST_POST: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          case (mode_q)
            MODE_START: begin
              cmd_o.op       = DP_KEY_TAIL;
              ad_closed_d    = 1'b0;
              text_started_d = 1'b0;
            end
            MODE_ENC, MODE_DEC: begin
              cmd_o.op       = DP_TEXT;
              cmd_o.decrypt  = (mode_q == MODE_DEC);
              cmd_o.kind     = KIND_TEXT;
              text_started_d = 1'b1;
            end
            MODE_FIN: begin
              cmd_o.op   = DP_KEY_TAIL;
              cmd_o.kind = KIND_TAG;
            end
            default: cmd_o.op = DP_NOP;
          endcase
        end
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      mode_q         <= '0;
      rnd_q          <= '0;
      ad_closed_q    <= 1'b0;
      text_started_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      rnd_q          <= rnd_d;
      ad_closed_q    <= ad_closed_d;
      text_started_q <= text_started_d;
      out_valid_q    <= out_valid_d;
      if (accept) begin
        mode_q <= in_mode_i;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/ascon_dp.sv
// Datapath: permutation state, key registers, round unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module ascon_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ascon_pkg::dp_cmd_t                  cmd_i,
  input  wire ascon_pkg::in_item_t                 in_data_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [ascon_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [ascon_pkg::WordW-1:0]         cfg_data_i,
  output ascon_pkg::out_item_t                     out_data_o
);
  import ascon_pkg::*;

  state_t           s_q, s_d;
  logic [WordW-1:0] key_first_q, key_second_q;
  logic [WordW-1:0] data_q, nonce_q;
  logic [WordW-1:0] text_word;
  out_item_t        res_q, res_d;

  assign text_word = data_q ^ s_q[0];

  always_comb begin
    s_d = s_q;
    case (cmd_i.op)
      DP_LOAD_IV: begin
        s_d[0] = ASCON_IV;
        s_d[1] = key_first_q;
        s_d[2] = key_second_q;
        s_d[3] = data_q;
        s_d[4] = nonce_q;
      end
      DP_ABSORB:   s_d[0] = s_q[0] ^ data_q;
      DP_KEY_HEAD: begin
        s_d[1] = s_q[1] ^ key_first_q;
        s_d[2] = s_q[2] ^ key_second_q;
      end
      DP_ROUND:    s_d = ascon_round(s_q, cmd_i.rnd);
      DP_KEY_TAIL: begin
        s_d[3] = s_q[3] ^ key_first_q;
        s_d[4] = s_q[4] ^ key_second_q;
      end
      DP_TEXT:     s_d[0] = cmd_i.decrypt ? data_q : text_word;
      default:     s_d = s_q;
    endcase
    if (cmd_i.close_ad) begin
      s_d[4] = s_d[4] ^ DOMAIN_SEP;
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.kind = cmd_i.kind;
    case (cmd_i.kind)
      KIND_TEXT: res_d.word_out = text_word;
      KIND_TAG: begin
        res_d.word_out   = s_q[3] ^ key_first_q;
        res_d.tag_second = s_q[4] ^ key_second_q;
      end
      default: res_d.word_out = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q          <= '0;
      key_first_q  <= '0;
      key_second_q <= '0;
    end else begin
      s_q <= s_d;
      if (cfg_we_i && cfg_idx_i == CFG_KEY_FIRST) begin
        key_first_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_KEY_SECOND) begin
        key_second_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      data_q  <= in_data_i.data;
      nonce_q <= in_data_i.nonce_second;
    end
    if (cmd_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule
`default_nettype wire

### rtl/core/ascon_aead_core.sv
// Top level of the Ascon-128 AEAD core: controller plus datapath.
// Items pass a prepare step, the rounds and a finish step: ignored or first-text
// items run no rounds, associated data and later text blocks run the data rounds,
// start and finalize the init rounds, one round per cycle; input waits until finish.
// The result register frees the input side while a result waits to be taken.
// Reset (async, active low) clears state, keys, flags and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module ascon_aead_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire ascon_pkg::in_item_t            in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output ascon_pkg::out_item_t                out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ascon_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ascon_pkg::WordW-1:0]    cfg_data_i
);
  import ascon_pkg::*;

  dp_cmd_t cmd;

  ascon_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ascon_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
